@@ hw/rtl/spq_pkg.sv @@
package spq_pkg;

    localparam int DEPTH     = 32;
    localparam int KEY_BITS  = 16;
    localparam int DATA_BITS = 16;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    typedef logic [KEY_BITS-1:0]  t_key;
    typedef logic [DATA_BITS-1:0] t_data;
    typedef logic [CNT_W-1:0]     t_count;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_PUSH   = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    typedef struct packed {
        logic cmp_en;
        logic force_hit;
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

@@ hw/rtl/spq_cell.sv @@
module spq_cell (
    input  logic              i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic              i_occ,
    input  spq_pkg::t_key     i_new_key,
    input  spq_pkg::t_data    i_new_pay,
    input  spq_pkg::t_key     i_left_key,
    input  spq_pkg::t_data    i_left_pay,
    input  spq_pkg::t_key     i_right_key,
    input  spq_pkg::t_data    i_right_pay,
    input  logic              i_found,
    output logic              o_found,
    output spq_pkg::t_key     o_key,
    output spq_pkg::t_data    o_pay
);
    import spq_pkg::*;

    t_key  r_key;
    t_data r_pay;
    logic  r_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_hit <= i_ctl.force_hit || !i_occ || (r_key >= i_new_key);
        end
        if (i_ctl.ins) begin
            if (i_found) begin
                r_key <= i_left_key;
                r_pay <= i_left_pay;
            end else if (r_hit) begin
                r_key <= i_new_key;
                r_pay <= i_new_pay;
            end
        end else if (i_ctl.rem) begin
            r_key <= i_right_key;
            r_pay <= i_right_pay;
        end
    end

    assign o_found = i_found | r_hit;
    assign o_key   = r_key;
    assign o_pay   = r_pay;

endmodule

@@ hw/rtl/sorted_priority_queue_with_stack_core.sv @@
// Sorted priority queue with a push-front path, built as a row of entry cells.
// Input channel: i_in_valid / o_in_ready carry one request beat (i_req_type,
// i_priority_key, i_payload). Output channel: o_out_valid / i_out_ready carry
// one result beat per request (o_status, o_removed_valid, o_removed_key,
// o_removed_payload, o_entry_count).
// On the accept edge of a request every cell registers its own
// key compare against the request key; in the next cycle the compare bits
// ripple through the row as a found chain and every cell loads its left
// neighbor, the new entry, its right neighbor or holds. The result is in the
// output register in the cycle after the accept edge. No new request is taken
// until that update is done.
// A new request is taken while a result waits only when the receiver takes
// that result on the same edge; if the receiver stalls, the next request
// waits in the input channel and the queue holds.
// Reset empties the queue at once (entry count zero) and no request is taken
// while it is held; entry contents are not cleared and are never read before
// being written.
module sorted_priority_queue_with_stack_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_req_type,
    input  spq_pkg::t_key    i_priority_key,
    input  spq_pkg::t_data   i_payload,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_status,
    output logic             o_removed_valid,
    output spq_pkg::t_key    o_removed_key,
    output spq_pkg::t_data   o_removed_payload,
    output spq_pkg::t_count  o_entry_count
);
    import spq_pkg::*;

    t_state    r_state;
    t_req      r_req;
    t_key      r_key;
    t_data     r_pay;
    t_count    r_count;
    t_count    n_count;
    logic      r_out_valid;
    t_status   r_status;
    t_status   n_status;
    logic      r_rvalid;
    logic      n_rvalid;
    t_key      r_rkey;
    t_data     r_rpay;
    logic      in_acc;
    logic      full;
    logic      empty;
    t_cell_ctl ctl;
    t_key      cell_new_key;
    t_data     cell_new_pay;

    t_key  cell_key [DEPTH];
    t_data cell_pay [DEPTH];
    logic  found    [DEPTH+1];

    assign o_in_ready = i_rst_n && (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;
    assign full       = (r_count == t_count'(DEPTH));
    assign empty      = (r_count == '0);

    always_comb begin
        ctl.cmp_en    = in_acc;
        ctl.force_hit = (t_req'(i_req_type) == REQ_PUSH);
        ctl.ins       = 1'b0;
        ctl.rem       = 1'b0;
        n_count       = r_count;
        n_status      = ST_DONE;
        n_rvalid      = 1'b0;
        if (r_state == S_EXEC) begin
            case (r_req)
                REQ_INSERT, REQ_PUSH: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        ctl.ins = 1'b1;
                        n_count = r_count + t_count'(1);
                    end
                end
                REQ_REMOVE: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        ctl.rem  = 1'b1;
                        n_rvalid = 1'b1;
                        n_count  = r_count - t_count'(1);
                    end
                end
                REQ_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    assign cell_new_key = (r_state == S_IDLE) ? i_priority_key : r_key;
    assign cell_new_pay = r_pay;
    assign found[0]     = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occ       (t_count'(g) < r_count),
            .i_new_key   (cell_new_key),
            .i_new_pay   (cell_new_pay),
            .i_left_key  ((g == 0) ? cell_new_key : cell_key[(g == 0) ? 0 : g-1]),
            .i_left_pay  ((g == 0) ? cell_new_pay : cell_pay[(g == 0) ? 0 : g-1]),
            .i_right_key (cell_key[(g == DEPTH-1) ? g : g+1]),
            .i_right_pay (cell_pay[(g == DEPTH-1) ? g : g+1]),
            .i_found     (found[g]),
            .o_found     (found[g+1]),
            .o_key       (cell_key[g]),
            .o_pay       (cell_pay[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_EXEC;
                    end
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_state     <= S_IDLE;
                    r_count     <= n_count;
                    r_out_valid <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= t_req'(i_req_type);
            r_key <= i_priority_key;
            r_pay <= i_payload;
        end
        if (r_state == S_EXEC) begin
            r_status <= n_status;
            r_rvalid <= n_rvalid;
            r_rkey   <= n_rvalid ? cell_key[0] : '0;
            r_rpay   <= n_rvalid ? cell_pay[0] : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_removed_valid   = r_rvalid;
    assign o_removed_key     = r_rkey;
    assign o_removed_payload = r_rpay;
    assign o_entry_count     = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(DEPTH))
        else $error("entry count beyond depth");

    a_exec_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !r_out_valid)
        else $error("result register busy during update");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EXEC))
        else $error("accepted beat not executed");

    a_removed_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rvalid) |-> (r_status == ST_DONE))
        else $error("removed entry with failing status");

endmodule

@@ tb/sorted_priority_queue_with_stack_core_tb.sv @@
`timescale 1ns / 100ps

module sorted_priority_queue_with_stack_core_tb;
    import spq_pkg::*;

    localparam int HOLD_CYCLES      = 300;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int RANDOM_PER_PHASE = 334;
    localparam int N_ROWS           = 18;
    localparam int TX_IDLE [3]      = '{17, 82, 0};
    localparam int RX_IDLE [3]      = '{82, 17, 0};

    typedef struct packed {
        t_status status;
        logic    removed_valid;
        t_key    removed_key;
        t_data   removed_payload;
        t_count  entry_count;
    } t_result;

    typedef struct {
        t_key  key;
        t_data data;
    } t_entry;

    typedef struct {
        bit      pinned;
        t_result result;
    } t_pinned_result;

    typedef struct {
        t_req    req;
        t_key    key;
        t_data   data;
        int      reps;
        bit      rand_key;
        bit      pinned;
        t_result result;
    } t_row;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    localparam t_result UNPINNED  = '0;
    localparam t_result EMPTY_HIT = '{ST_EMPTY, 1'b0, '0, '0, '0};
    localparam t_result CLEARED   = '{ST_DONE, 1'b0, '0, '0, '0};
    localparam t_result FULL_HIT  = '{ST_FULL, 1'b0, '0, '0, t_count'(DEPTH)};

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_in_valid = 1'b0;
    logic    o_in_ready;
    logic [1:0] i_req_type = '0;
    t_key    i_priority_key = '0;
    t_data   i_payload = '0;
    logic    o_out_valid;
    logic    i_out_ready = 1'b0;
    logic [1:0] o_status;
    logic    o_removed_valid;
    t_key    o_removed_key;
    t_data   o_removed_payload;
    t_count  o_entry_count;

    t_entry         held_entries[$];
    t_result        pending_results[$];
    t_pinned_result pinned_results[$];
    t_row           dir_rows [N_ROWS];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_requests = 0;
    int holds_granted = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int error_count = 0;
    int results_checked = 0;
    int full_rejects = 0;
    int empty_removes = 0;
    int fill_peak = 0;
    int req_tally [4] = '{0, 0, 0, 0};

    sorted_priority_queue_with_stack_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_req_type        (i_req_type),
        .i_priority_key    (i_priority_key),
        .i_payload         (i_payload),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_removed_valid   (o_removed_valid),
        .o_removed_key     (o_removed_key),
        .o_removed_payload (o_removed_payload),
        .o_entry_count     (o_entry_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_result serve_request(t_req req, t_key key, t_data data);
        t_result r;
        t_entry  e;
        int      pos;
        int      i;
        r = '{ST_DONE, 1'b0, '0, '0, '0};
        e.key = key;
        e.data = data;
        case (req)
            REQ_INSERT, REQ_PUSH: begin
                if (held_entries.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (req == REQ_PUSH) begin
                    held_entries.push_front(e);
                end else begin
                    pos = held_entries.size();
                    for (i = 0; i < held_entries.size(); i++) begin
                        if (held_entries[i].key >= key) begin
                            pos = i;
                            break;
                        end
                    end
                    held_entries.insert(pos, e);
                end
            end
            REQ_REMOVE: begin
                if (held_entries.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    e = held_entries.pop_front();
                    r.removed_valid = 1'b1;
                    r.removed_key = e.key;
                    r.removed_payload = e.data;
                end
            end
            default: begin
                held_entries.delete();
            end
        endcase
        r.entry_count = t_count'(held_entries.size());
        return r;
    endfunction

    function automatic t_key pick_key();
        int p;
        p = $urandom_range(9);
        if (p < 4) return t_key'($urandom_range(7));
        if (p == 4) return ($urandom_range(1) == 0) ? '0 : '1;
        return t_key'($urandom);
    endfunction

    function automatic t_req pick_req(t_mix mix);
        int p;
        p = $urandom_range(99);
        case (mix)
            MIX_FILL: begin
                if (p < 60) return REQ_INSERT;
                if (p < 85) return REQ_PUSH;
                if (p < 97) return REQ_REMOVE;
            end
            MIX_DRAIN: begin
                if (p < 15) return REQ_INSERT;
                if (p < 23) return REQ_PUSH;
                if (p < 98) return REQ_REMOVE;
            end
            default: begin
                if (p < 35) return REQ_INSERT;
                if (p < 55) return REQ_PUSH;
                if (p < 97) return REQ_REMOVE;
            end
        endcase
        return REQ_CLEAR;
    endfunction

    task automatic send_item(t_req req, t_key key, t_data data, bit pinned, t_result result);
        t_pinned_result pr;
        pr.pinned = pinned;
        pr.result = result;
        pinned_results.push_back(pr);
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_priority_key <= key;
        i_payload      <= data;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic sender_gap();
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left = 0;
        end else if (holds_granted != hold_requests) begin
            holds_granted = hold_requests;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result        want;
        t_pinned_result pr;
        bit             moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        error_count++;
                    end
                    if (o_removed_valid !== want.removed_valid) begin
                        $error("removed_valid: expected %0d, got %0d",
                               want.removed_valid, o_removed_valid);
                        error_count++;
                    end
                    if (o_removed_key !== want.removed_key) begin
                        $error("removed_key: expected 0x%h, got 0x%h",
                               want.removed_key, o_removed_key);
                        error_count++;
                    end
                    if (o_removed_payload !== want.removed_payload) begin
                        $error("removed_payload: expected 0x%h, got 0x%h",
                               want.removed_payload, o_removed_payload);
                        error_count++;
                    end
                    if (o_entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, o_entry_count);
                        error_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                pr = pinned_results.pop_front();
                want = serve_request(t_req'(i_req_type), i_priority_key, i_payload);
                pending_results.push_back(pr.pinned ? pr.result : want);
                req_tally[i_req_type]++;
                if (want.status == ST_FULL) full_rejects++;
                if (want.status == ST_EMPTY) empty_removes++;
                if (int'(want.entry_count) > fill_peak) fill_peak = want.entry_count;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", idle_cycles);
                $display("sorted_priority_queue_with_stack_core_tb failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_mix mix;
        int   mix_left;
        int   ph;
        int   n;
        int   r;
        mix = MIX_FILL;
        mix_left = 0;
        dir_rows = '{
            '{REQ_REMOVE, 16'h0000, 16'h0000, 1,  1'b0, 1'b1, EMPTY_HIT},
            '{REQ_INSERT, 16'h8000, 16'h1234, 1,  1'b0, 1'b0, UNPINNED},
            '{REQ_INSERT, 16'hFFFF, 16'hFFFF, 1,  1'b0, 1'b0, UNPINNED},
            '{REQ_INSERT, 16'h0000, 16'h0000, 1,  1'b0, 1'b0, UNPINNED},
            '{REQ_INSERT, 16'h8000, 16'hAAAA, 1,  1'b0, 1'b0, UNPINNED},
            '{REQ_PUSH,   16'hFFFF, 16'h5555, 1,  1'b0, 1'b0, UNPINNED},
            '{REQ_REMOVE, 16'h0000, 16'h0000, 5,  1'b0, 1'b0, UNPINNED},
            '{REQ_REMOVE, 16'hFFFF, 16'hFFFF, 1,  1'b0, 1'b1, EMPTY_HIT},
            '{REQ_PUSH,   16'h0001, 16'h0001, 1,  1'b0, 1'b0, UNPINNED},
            '{REQ_CLEAR,  16'hFFFF, 16'hFFFF, 1,  1'b0, 1'b1, CLEARED},
            '{REQ_REMOVE, 16'h0000, 16'h0000, 1,  1'b0, 1'b1, EMPTY_HIT},
            '{REQ_INSERT, 16'h0000, 16'h0000, DEPTH, 1'b1, 1'b0, UNPINNED},
            '{REQ_INSERT, 16'h0000, 16'h0000, 1,  1'b0, 1'b1, FULL_HIT},
            '{REQ_PUSH,   16'hFFFF, 16'hFFFF, 1,  1'b0, 1'b1, FULL_HIT},
            '{REQ_REMOVE, 16'h0000, 16'h0000, 1,  1'b0, 1'b0, UNPINNED},
            '{REQ_PUSH,   16'h0000, 16'hFFFF, 1,  1'b0, 1'b0, UNPINNED},
            '{REQ_REMOVE, 16'h0000, 16'h0000, 1,  1'b0, 1'b0, UNPINNED},
            '{REQ_CLEAR,  16'h0000, 16'h0000, 1,  1'b0, 1'b1, CLEARED}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (ph = 0; ph < 3; ph++) begin
            tx_idle_pct = TX_IDLE[ph];
            rx_idle_pct = RX_IDLE[ph];
            // stall the result side while requests keep coming
            if (ph == 2) hold_requests++;
            if (ph == 0) begin
                for (r = 0; r < N_ROWS; r++) begin
                    for (n = 0; n < dir_rows[r].reps; n++) begin
                        send_item(dir_rows[r].req,
                                  dir_rows[r].rand_key ? pick_key() : dir_rows[r].key,
                                  dir_rows[r].rand_key ? t_data'($urandom) : dir_rows[r].data,
                                  dir_rows[r].pinned, dir_rows[r].result);
                        sender_gap();
                    end
                end
            end
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (mix_left == 0) begin
                    mix = t_mix'($urandom_range(2));
                    mix_left = $urandom_range(16, 64);
                end
                mix_left--;
                send_item(pick_req(mix), pick_key(), t_data'($urandom), 1'b0, UNPINNED);
                sender_gap();
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("requests: %0d insert, %0d push, %0d remove, %0d clear; %0d results checked",
                 req_tally[REQ_INSERT], req_tally[REQ_PUSH], req_tally[REQ_REMOVE],
                 req_tally[REQ_CLEAR], results_checked);
        $display("full-store rejects %0d, empty removes %0d, deepest fill %0d of %0d",
                 full_rejects, empty_removes, fill_peak, DEPTH);
        if (error_count == 0) begin
            $display("sorted_priority_queue_with_stack_core_tb passed");
        end else begin
            $display("sorted_priority_queue_with_stack_core_tb failed");
        end
        $finish;
    end

endmodule
